@@ rtl/ssnr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssnr_pkg
// Shared types, constants and glyph tables for the seven-segment raster.
// ---------------------------------------------------------------------------
package ssnr_pkg;

  localparam int GLYPH_W    = 13;
  localparam int GLYPH_H    = 23;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int NUM_BITS   = 31;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic {
    REG_COLOR  = 1'b0,
    REG_FORMAT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    SEG_NONE = 3'd0,
    SEG_TOP  = 3'd1,
    SEG_UL   = 3'd2,
    SEG_UR   = 3'd3,
    SEG_MID  = 3'd4,
    SEG_LL   = 3'd5,
    SEG_LR   = 3'd6,
    SEG_BOT  = 3'd7
  } seg_code_t;

  typedef struct packed {
    logic       fin;
    logic       hit;
    logic [3:0] slot;
    logic [4:0] row;
    logic [3:0] col;
  } srch_res_t;

  // segment under one glyph pixel
  function automatic seg_code_t glyph_seg(input logic [4:0] row, input logic [3:0] col);
    logic [3:0] side;
    logic [3:0] lo;
    seg_code_t  lft;
    seg_code_t  rgt;
    seg_code_t  bar;
    seg_code_t  code;
    side = 4'd0;
    lo   = 4'd1;
    bar  = SEG_NONE;
    case (row) inside
      5'd0, 5'd1: begin
        bar = SEG_TOP;
      end
      5'd2: begin
        side = 4'd1; bar = SEG_TOP; lo = 4'd2;
      end
      5'd3, 5'd9, 5'd13, 5'd19: begin
        side = 4'd2;
      end
      [5'd4:5'd8], [5'd14:5'd18]: begin
        side = 4'd3;
      end
      5'd10, 5'd12: begin
        side = 4'd1; bar = SEG_MID; lo = 4'd2;
      end
      5'd11: begin
        bar = SEG_MID;
      end
      5'd20: begin
        side = 4'd1; bar = SEG_BOT; lo = 4'd2;
      end
      5'd21, 5'd22: begin
        bar = SEG_BOT;
      end
      default: begin
        side = 4'd0;
      end
    endcase
    if (row >= 5'd12) begin
      lft = SEG_LL;
      rgt = SEG_LR;
    end else begin
      lft = SEG_UL;
      rgt = SEG_UR;
    end
    if (col < side) begin
      code = lft;
    end else if (col > 4'(GLYPH_W - 1) - side) begin
      code = rgt;
    end else if (bar != SEG_NONE && col >= lo && col <= 4'(GLYPH_W - 1) - lo) begin
      code = bar;
    end else begin
      code = SEG_NONE;
    end
    return code;
  endfunction

  // lit segments of a digit, bit n set for segment n, bit 0 unused
  function automatic logic [7:0] seg_mask(input logic [3:0] digit);
    logic [6:0] segs;
    unique case (digit)
      4'd0:    segs = 7'h77;
      4'd1:    segs = 7'h24;
      4'd2:    segs = 7'h5D;
      4'd3:    segs = 7'h6D;
      4'd4:    segs = 7'h2E;
      4'd5:    segs = 7'h6B;
      4'd6:    segs = 7'h7B;
      4'd7:    segs = 7'h25;
      4'd8:    segs = 7'h7F;
      4'd9:    segs = 7'h6F;
      default: segs = 7'h00;
    endcase
    return {segs, 1'b0};
  endfunction

endpackage
`default_nettype wire

@@ rtl/seven_segment_number_raster.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// seven_segment_number_raster
// Right-aligned seven-segment rendering of a stored decimal number.
//
//   channel  dir   contents
//   in_*     in    tuser: operation; tdata: number, pixel_x, pixel_y
//   out_*    out   tuser: lit; tdata: pixel_value
//   cfg_*    in    register 0 digit_color at 0x0, register 1 pixel_format at 0x4
//
// load: one bit per cycle through the decimal shift-and-correct unit
// read: one slot pitch subtracted per cycle
// one item at a time; in_tready is low while an item is being worked on
// a finished read waits in the output register while the next item is taken
// synchronous active-low reset clears the digits to a single zero
// ---------------------------------------------------------------------------
module seven_segment_number_raster #(
  parameter int GAP_W       = 2,
  parameter int FIELD_W     = 118,
  parameter int DIGIT_SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // number[30:0], pixel_x[37:31], pixel_y[42:38], zero
  input  wire logic        in_tuser,   // operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // pixel_value[31:0]
  output logic             out_tuser,  // lit
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOAD   = 3'b010,
    ST_SEARCH = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [31:0]         color_r;
  logic                format_r;
  logic [3:0]          digit_r [ssnr_pkg::NUM_DIGITS];
  logic [3:0]          count_r;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_pix_r;
  logic                out_lit_r;

  logic                in_xfer;
  logic                load_start;
  logic                read_start;
  logic                conv_done;
  logic [ssnr_pkg::BCD_W-1:0] conv_digits;
  logic [3:0]          conv_count;
  ssnr_pkg::srch_res_t res;
  logic                out_free;
  logic                res_take;
  ssnr_pkg::seg_code_t code;
  logic [7:0]          mask;
  logic                lit;
  logic [31:0]         pix;
  logic                cfg_wr;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign load_start = in_xfer && (in_tuser == ssnr_pkg::OP_LOAD);
  assign read_start = in_xfer && (in_tuser == ssnr_pkg::OP_READ);

  ssnr_bcd_conv u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (load_start),
    .number (in_tdata[30:0]),
    .done   (conv_done),
    .digits (conv_digits),
    .count  (conv_count)
  );

  ssnr_slot_search #(
    .GAP_W       (GAP_W),
    .FIELD_W     (FIELD_W),
    .DIGIT_SLOTS (DIGIT_SLOTS)
  ) u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (read_start),
    .pixel_x     (in_tdata[37:31]),
    .pixel_y     (in_tdata[42:38]),
    .digit_count (count_r),
    .res         (res)
  );

  assign out_free = !out_valid_r || out_tready;
  assign res_take = (state_r == ST_SEARCH) && res.fin && out_free;

  // glyph lookup for the finished search
  assign code = ssnr_pkg::glyph_seg(res.row, res.col);
  assign mask = ssnr_pkg::seg_mask(digit_r[res.slot]);
  assign lit  = res.hit && mask[code];
  assign pix  = !lit ? 32'd0 : (format_r ? color_r : {16'd0, color_r[15:0]});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (load_start) begin
          state_nxt = ST_LOAD;
        end else if (read_start) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_LOAD: begin
        if (conv_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= 4'd1;
      for (int i = 0; i < ssnr_pkg::NUM_DIGITS; i++) begin
        digit_r[i] <= 4'd0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_LOAD && conv_done) begin
        count_r <= conv_count;
        for (int i = 0; i < ssnr_pkg::NUM_DIGITS; i++) begin
          digit_r[i] <= conv_digits[i*4 +: 4];
        end
      end
    end
    if (res_take) begin
      out_pix_r <= pix;
      out_lit_r <= lit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = out_lit_r;

  // register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r  <= 32'hFFFF_FFFF;
      format_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        ssnr_pkg::REG_COLOR:  color_r  <= cfg_pwdata;
        ssnr_pkg::REG_FORMAT: format_r <= cfg_pwdata[0];
        default:              color_r  <= color_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      ssnr_pkg::REG_COLOR:  cfg_prdata = color_r;
      ssnr_pkg::REG_FORMAT: cfg_prdata = {31'd0, format_r};
      default:              cfg_prdata = 32'd0;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != 4'd0) && (count_r <= 4'(ssnr_pkg::NUM_DIGITS)))
    else $error("digit count out of range");

  a_conv_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    conv_done |-> (state_r == ST_LOAD))
    else $error("conversion finished outside a load");

  a_hit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (res_take && res.hit) |-> (res.slot < count_r))
    else $error("hit on a slot beyond the significant digits");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input taken again before the item finished");
`endif

endmodule
`default_nettype wire

@@ rtl/ssnr_bcd_conv.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssnr_bcd_conv
// Binary to decimal conversion, one shift-and-correct step per cycle.
// ---------------------------------------------------------------------------
module ssnr_bcd_conv (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire logic [ssnr_pkg::NUM_BITS-1:0]         number,
  output logic                                       done,
  output logic [ssnr_pkg::BCD_W-1:0]                 digits,
  output logic [3:0]                                 count
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [4:0]                        cnt_r, cnt_nxt;
  logic [ssnr_pkg::BCD_W-1:0]        bcd_r, bcd_nxt;
  logic [ssnr_pkg::NUM_BITS-1:0]     bin_r, bin_nxt;
  logic [ssnr_pkg::BCD_W-1:0]        adj;

  // add three to every digit of five or more
  always_comb begin
    for (int i = 0; i < ssnr_pkg::NUM_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    bcd_nxt  = bcd_r;
    bin_nxt  = bin_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'(ssnr_pkg::NUM_BITS);
      bcd_nxt  = '0;
      bin_nxt  = number;
    end else if (busy_r) begin
      bcd_nxt = {adj[ssnr_pkg::BCD_W-2:0], bin_r[ssnr_pkg::NUM_BITS-1]};
      bin_nxt = {bin_r[ssnr_pkg::NUM_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    bcd_r <= bcd_nxt;
    bin_r <= bin_nxt;
  end

  // significant digits, at least one
  always_comb begin
    count = 4'd1;
    for (int i = 0; i < ssnr_pkg::NUM_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        count = 4'(i + 1);
      end
    end
  end

  assign done   = done_r;
  assign digits = bcd_r;

endmodule
`default_nettype wire

@@ rtl/ssnr_slot_search.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssnr_slot_search
// Finds the digit slot and glyph column of a pixel by repeated pitch subtract.
// ---------------------------------------------------------------------------
module ssnr_slot_search #(
  parameter int GAP_W       = 2,
  parameter int FIELD_W     = 118,
  parameter int DIGIT_SLOTS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [6:0]          pixel_x,
  input  wire logic [4:0]          pixel_y,
  input  wire logic [3:0]          digit_count,
  output ssnr_pkg::srch_res_t      res
);

  localparam int PITCH = ssnr_pkg::GLYPH_W + GAP_W;
  localparam int RW    = $clog2(FIELD_W + PITCH);

  logic          busy_r, busy_nxt;
  logic          fin_r, fin_nxt;
  logic          hit_r, hit_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [3:0]    k_r, k_nxt;
  logic [3:0]    limit_r, limit_nxt;
  logic [4:0]    row_r, row_nxt;
  logic          outside;
  logic [RW-1:0] rem_init;

  assign outside  = ({3'b0, pixel_x} >= 10'(FIELD_W)) ||
                    (pixel_y >= 5'(ssnr_pkg::GLYPH_H));
  assign rem_init = RW'(10'(FIELD_W - 1) - {3'b0, pixel_x});

  always_comb begin
    busy_nxt  = busy_r;
    fin_nxt   = fin_r;
    hit_nxt   = hit_r;
    rem_nxt   = rem_r;
    k_nxt     = k_r;
    limit_nxt = limit_r;
    row_nxt   = row_r;
    if (start) begin
      busy_nxt  = !outside;
      fin_nxt   = outside;
      hit_nxt   = 1'b0;
      rem_nxt   = rem_init;
      k_nxt     = 4'd0;
      row_nxt   = pixel_y;
      limit_nxt = (digit_count < 4'(DIGIT_SLOTS)) ? digit_count : 4'(DIGIT_SLOTS);
    end else if (busy_r) begin
      if (rem_r >= RW'(PITCH)) begin
        if ((k_r + 4'd1) < limit_r) begin
          rem_nxt = rem_r - RW'(PITCH);
          k_nxt   = k_r + 4'd1;
        end else begin
          busy_nxt = 1'b0;
          fin_nxt  = 1'b1;
        end
      end else begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
        hit_nxt  = rem_r < RW'(ssnr_pkg::GLYPH_W);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      hit_r  <= hit_nxt;
    end
    rem_r   <= rem_nxt;
    k_r     <= k_nxt;
    limit_r <= limit_nxt;
    row_r   <= row_nxt;
  end

  assign res.fin  = fin_r;
  assign res.hit  = hit_r;
  assign res.slot = k_r;
  assign res.row  = row_r;
  assign res.col  = 4'(ssnr_pkg::GLYPH_W - 1) - rem_r[3:0];

endmodule
`default_nettype wire
